@@ rtl/dsps_pkg.sv @@
package dsps_pkg;

  // Widths of the timer and position counters.
  localparam int TIMER_BITS    = 16;
  localparam int POSITION_BITS = 20;

  // Speed limit after reset.
  localparam logic [TIMER_BITS-1:0] MIN_RELOAD_RST = TIMER_BITS'(100);

  // Request codes.
  typedef enum logic [1:0] {
    ACT_TICK = 2'd0,
    ACT_RUN  = 2'd1,
    ACT_MOVE = 2'd2,
    ACT_STOP = 2'd3
  } action_t;

  // State of one motor.
  typedef struct packed {
    logic [TIMER_BITS-1:0]    divider;
    logic [1:0]               phase;
    logic [POSITION_BITS-1:0] count;
    logic [3:0]               coils;
  } motor_t;

  // Motor state after a tick, with the step flag.
  typedef struct packed {
    motor_t m;
    logic   step;
  } tick_t;

  // One result.
  typedef struct packed {
    logic [3:0] coils_left;
    logic [3:0] coils_right;
    logic       step_left;
    logic       step_right;
    logic       at_target_left;
    logic       at_target_right;
    logic       periods_accepted;
  } result_t;

  // Full-step coil patterns, lines A,B,C,D as bits 3..0.
  function automatic logic [3:0] phase_coils(input logic [1:0] idx);
    logic [3:0] pat;
    case (idx)
      2'd0:    pat = 4'h6;
      2'd1:    pat = 4'h5;
      2'd2:    pat = 4'h9;
      2'd3:    pat = 4'hA;
      default: pat = 4'h0;
    endcase
    return pat;
  endfunction

  // One timer tick for one motor: with a nonzero period, count the divider, then halt or advance.
  function automatic tick_t motor_tick(
    input logic [TIMER_BITS-1:0]    period,
    input motor_t                   cur,
    input logic [POSITION_BITS-1:0] goal,
    input logic                     continuous,
    input logic                     mirrored
  );
    tick_t      res;
    logic [1:0] ph;
    res      = '{m: cur, step: 1'b0};
    ph       = cur.phase + 2'd1;
    if (period == '0) begin
      res.m.divider = '0;
    end else if (cur.divider < period) begin
      res.m.divider = cur.divider + TIMER_BITS'(1);
    end else begin
      res.m.divider = '0;
      if (!continuous && (cur.count == goal)) begin
        res.m.coils = 4'h0;
      end else begin
        res.m.phase = ph;
        res.m.coils = phase_coils(mirrored ? (2'd3 - ph) : ph);
        res.m.count = cur.count + POSITION_BITS'(1);
        res.step    = 1'b1;
      end
    end
    return res;
  endfunction

endpackage

@@ rtl/dual_stepper_position_sequencer_core.sv @@
// Full-step sequencer for two stepper motors.
// Input channel (in_valid / in_stall) carries one request per item: a timer
// tick, a run command with two periods, a move command with periods and
// targets, or a stop. Every request gives exactly one result on the output
// channel (out_valid / out_stall) with both coil patterns, the step flags,
// the at-target flags and the period-accept flag.
// The motor state and the result are both registered when a request is accepted;
// the result enters the output register, or the skid register while the output
// register holds a result that is not taken. One request is taken every cycle
// while in_stall is low; dividers, phases and step counters update with each.
// A two-entry output queue (output register plus skid register) lets input
// flow while a result waits: when the receiver stalls, the current result
// holds, one more request is taken into the skid register, and in_stall
// rises until the receiver frees a slot.
// The user must write min_reload (cfg_we / cfg_wdata) only while the block is
// idle; the block does not enforce this. Reset (rst_n low, synchronous) stops
// both motors, turns all coils off, clears counts, goals and phases, selects
// position mode, empties the output queue and sets the speed limit min_reload to 100.
module dual_stepper_position_sequencer_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [dsps_pkg::TIMER_BITS-1:0]    cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         in_action,
  input  logic [dsps_pkg::TIMER_BITS-1:0]    in_reload_left,
  input  logic [dsps_pkg::TIMER_BITS-1:0]    in_reload_right,
  input  logic [dsps_pkg::POSITION_BITS-1:0] in_target_left_steps,
  input  logic [dsps_pkg::POSITION_BITS-1:0] in_target_right_steps,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [3:0]                         out_coils_left,
  output logic [3:0]                         out_coils_right,
  output logic                               out_step_left,
  output logic                               out_step_right,
  output logic                               out_at_target_left,
  output logic                               out_at_target_right,
  output logic                               out_periods_accepted
);
  import dsps_pkg::*;

  logic [TIMER_BITS-1:0]    min_reload_r;
  logic [TIMER_BITS-1:0]    period_left_r, period_left_nxt;
  logic [TIMER_BITS-1:0]    period_right_r, period_right_nxt;
  motor_t                   left_r, left_nxt;
  motor_t                   right_r, right_nxt;
  logic [POSITION_BITS-1:0] goal_left_r, goal_left_nxt;
  logic [POSITION_BITS-1:0] goal_right_r, goal_right_nxt;
  logic                     continuous_r, continuous_nxt;
  tick_t                    tick_left, tick_right;
  result_t                  res;
  result_t                  out_r, skid_r;
  logic                     out_valid_r, skid_valid_r;
  logic                     accept, pop;

  assign accept = in_valid && !in_stall;
  assign pop    = out_valid_r && !out_stall;

  // Tick outcome of both motors from the current state.
  assign tick_left  = motor_tick(period_left_r, left_r, goal_left_r, continuous_r, 1'b0);
  assign tick_right = motor_tick(period_right_r, right_r, goal_right_r, continuous_r, 1'b1);

  // Next motor state and the result of the request.
  always_comb begin
    period_left_nxt      = period_left_r;
    period_right_nxt     = period_right_r;
    left_nxt             = left_r;
    right_nxt            = right_r;
    goal_left_nxt        = goal_left_r;
    goal_right_nxt       = goal_right_r;
    continuous_nxt       = continuous_r;
    res                  = '0;
    case (action_t'(in_action))
      ACT_TICK: begin
        left_nxt       = tick_left.m;
        right_nxt      = tick_right.m;
        res.step_left  = tick_left.step;
        res.step_right = tick_right.step;
      end
      ACT_STOP: begin
        period_left_nxt   = '0;
        period_right_nxt  = '0;
        left_nxt.divider  = '0;
        right_nxt.divider = '0;
        left_nxt.coils    = 4'h0;
        right_nxt.coils   = 4'h0;
      end
      ACT_RUN, ACT_MOVE: begin
        if (action_t'(in_action) == ACT_RUN) begin
          continuous_nxt = 1'b1;
        end else begin
          continuous_nxt  = 1'b0;
          left_nxt.count  = '0;
          right_nxt.count = '0;
          goal_left_nxt   = in_target_left_steps;
          goal_right_nxt  = in_target_right_steps;
        end
        if ((in_reload_left >= min_reload_r) && (in_reload_right >= min_reload_r)) begin
          period_left_nxt      = in_reload_left;
          period_right_nxt     = in_reload_right;
          res.periods_accepted = 1'b1;
        end
      end
      default: begin
        res = '0;
      end
    endcase
    res.coils_left      = left_nxt.coils;
    res.coils_right     = right_nxt.coils;
    res.at_target_left  = !continuous_nxt && (left_nxt.count == goal_left_nxt);
    res.at_target_right = !continuous_nxt && (right_nxt.count == goal_right_nxt);
  end

  // Speed limit register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_reload_r <= MIN_RELOAD_RST;
    end else if (cfg_we) begin
      min_reload_r <= cfg_wdata;
    end
  end

  // Motor state, updated on every accepted request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_left_r  <= '0;
      period_right_r <= '0;
      left_r         <= '0;
      right_r        <= '0;
      goal_left_r    <= '0;
      goal_right_r   <= '0;
      continuous_r   <= 1'b0;
    end else if (accept) begin
      period_left_r  <= period_left_nxt;
      period_right_r <= period_right_nxt;
      left_r         <= left_nxt;
      right_r        <= right_nxt;
      goal_left_r    <= goal_left_nxt;
      goal_right_r   <= goal_right_nxt;
      continuous_r   <= continuous_nxt;
    end
  end

  // Output queue control: output register in front, skid register behind.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= accept;
      end else begin
        out_valid_r  <= accept;
      end
    end else if (accept) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Output queue payload.
  always_ff @(posedge clk) begin
    if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_r  <= skid_r;
        skid_r <= res;
      end else begin
        out_r  <= res;
      end
    end else if (accept) begin
      skid_r <= res;
    end
  end

  assign in_stall             = skid_valid_r;
  assign out_valid            = out_valid_r;
  assign out_coils_left       = out_r.coils_left;
  assign out_coils_right      = out_r.coils_right;
  assign out_step_left        = out_r.step_left;
  assign out_step_right       = out_r.step_right;
  assign out_at_target_left   = out_r.at_target_left;
  assign out_at_target_right  = out_r.at_target_right;
  assign out_periods_accepted = out_r.periods_accepted;

endmodule

@@ rtl/dsps_checker.sv @@
module dsps_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [3:0] out_coils_left,
  input logic [3:0] out_coils_right,
  input logic       out_step_left,
  input logic       out_step_right,
  input logic       out_periods_accepted
);

  // The output queue is empty after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  // A motor that advanced drives a live coil pattern.
  a_step_coils: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_step_left || out_step_right) |->
      (!out_step_left || out_coils_left != 4'h0) &&
      (!out_step_right || out_coils_right != 4'h0))
    else $error("step reported with all coils off");

  // A command that loads periods is not a tick, so no step can come with it.
  a_accept_no_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_periods_accepted |-> !out_step_left && !out_step_right)
    else $error("period accept and step in one result");

  // A stalled result holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_coils_left) &&
      $stable(out_coils_right) && $stable(out_periods_accepted))
    else $error("stalled result changed");

endmodule

bind dual_stepper_position_sequencer_core dsps_checker u_dsps_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_coils_left       (out_coils_left),
  .out_coils_right      (out_coils_right),
  .out_step_left        (out_step_left),
  .out_step_right       (out_step_right),
  .out_periods_accepted (out_periods_accepted)
);

@@ tb/tb_dual_stepper_position_sequencer_core.sv @@
module tb_dual_stepper_position_sequencer_core;
  timeunit 1ns;
  timeprecision 1ps;

  import dsps_pkg::*;

  // One request as driven on the input channel.
  typedef struct {
    action_t                  action;
    logic [TIMER_BITS-1:0]    reload_left;
    logic [TIMER_BITS-1:0]    reload_right;
    logic [POSITION_BITS-1:0] target_left;
    logic [POSITION_BITS-1:0] target_right;
  } motion_req_t;

  // Predicts the coil outputs of both motors and checks each result in order.
  class motion_scoreboard;
    // Full-step patterns for phases 0..3, four bits each, phase 0 lowest.
    localparam logic [15:0] FULL_STEP = 16'hA956;

    logic [TIMER_BITS-1:0]    min_reload;
    logic [TIMER_BITS-1:0]    period [2];
    logic [TIMER_BITS-1:0]    divider [2];
    logic [1:0]               phase [2];
    logic [POSITION_BITS-1:0] count [2];
    logic [POSITION_BITS-1:0] goal [2];
    logic [3:0]               coils [2];
    bit                       continuous;
    result_t                  pending [$];
    int                       errors;

    function new();
      min_reload = MIN_RELOAD_RST;
      for (int m = 0; m < 2; m++) begin
        period[m]  = '0;
        divider[m] = '0;
        phase[m]   = '0;
        count[m]   = '0;
        goal[m]    = '0;
        coils[m]   = '0;
      end
      continuous = 1'b0;
      errors     = 0;
    endfunction

    task report(string what);
      // Print the first couple of hundred mismatches only, but count them all.
      if (errors < 200) $display("mismatch at %0t ns: %s", $time, what);
      errors++;
    endtask

    // One timer tick for motor m (0 left, 1 right); returns 1 on an advancing step.
    function bit tick_motor(int m);
      if (period[m] == '0) begin
        divider[m] = '0;
        return 1'b0;
      end
      if (divider[m] < period[m]) begin
        divider[m]++;
        return 1'b0;
      end
      divider[m] = '0;
      // In position mode a motor that has reached its goal only drops its coils.
      if (!continuous && count[m] == goal[m]) begin
        coils[m] = 4'h0;
        return 1'b0;
      end
      phase[m]++;
      coils[m] = (m == 0) ? FULL_STEP[phase[m]*4 +: 4] : FULL_STEP[(2'd3 - phase[m])*4 +: 4];
      count[m]++;
      return 1'b1;
    endfunction

    // Update the motor state for an accepted request and queue its result.
    function void note_request(motion_req_t r);
      result_t want;
      want = '0;
      case (r.action)
        ACT_TICK: begin
          want.step_left  = tick_motor(0);
          want.step_right = tick_motor(1);
        end
        ACT_STOP: begin
          for (int m = 0; m < 2; m++) begin
            period[m]  = '0;
            divider[m] = '0;
            coils[m]   = '0;
          end
        end
        default: begin
          if (r.action == ACT_RUN) begin
            continuous = 1'b1;
          end else begin
            count[0]   = '0;
            count[1]   = '0;
            goal[0]    = r.target_left;
            goal[1]    = r.target_right;
            continuous = 1'b0;
          end
          // Both periods load together, and only when both meet the speed limit.
          if (r.reload_left >= min_reload && r.reload_right >= min_reload) begin
            period[0] = r.reload_left;
            period[1] = r.reload_right;
            want.periods_accepted = 1'b1;
          end
        end
      endcase
      want.coils_left      = coils[0];
      want.coils_right     = coils[1];
      want.at_target_left  = !continuous && count[0] == goal[0];
      want.at_target_right = !continuous && count[1] == goal[1];
      pending.push_back(want);
    endfunction

    task check_field(string name, logic [3:0] got, logic [3:0] want);
      if (got !== want) report($sformatf("%s is %h, expected %h", name, got, want));
    endtask

    // Compare a delivered result with the oldest expected one.
    task check_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        report("result delivered with no request outstanding");
        return;
      end
      want = pending.pop_front();
      check_field("coils_left", got.coils_left, want.coils_left);
      check_field("coils_right", got.coils_right, want.coils_right);
      check_field("step_left", got.step_left, want.step_left);
      check_field("step_right", got.step_right, want.step_right);
      check_field("at_target_left", got.at_target_left, want.at_target_left);
      check_field("at_target_right", got.at_target_right, want.at_target_right);
      check_field("periods_accepted", got.periods_accepted, want.periods_accepted);
    endtask
  endclass

  bit                       clk;
  logic                     rst_n = 1'b0;
  logic                     cfg_we = 1'b0;
  logic [TIMER_BITS-1:0]    cfg_wdata = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [1:0]               in_action = ACT_TICK;
  logic [TIMER_BITS-1:0]    in_reload_left = '0;
  logic [TIMER_BITS-1:0]    in_reload_right = '0;
  logic [POSITION_BITS-1:0] in_target_left_steps = '0;
  logic [POSITION_BITS-1:0] in_target_right_steps = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [3:0]               out_coils_left;
  logic [3:0]               out_coils_right;
  logic                     out_step_left;
  logic                     out_step_right;
  logic                     out_at_target_left;
  logic                     out_at_target_right;
  logic                     out_periods_accepted;

  motion_scoreboard sb = new();
  bit               idling = 1'b0;
  int               stall_left = 0;

  dual_stepper_position_sequencer_core dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_wdata             (cfg_wdata),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_action             (in_action),
    .in_reload_left        (in_reload_left),
    .in_reload_right       (in_reload_right),
    .in_target_left_steps  (in_target_left_steps),
    .in_target_right_steps (in_target_right_steps),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_coils_left        (out_coils_left),
    .out_coils_right       (out_coils_right),
    .out_step_left         (out_step_left),
    .out_step_right        (out_step_right),
    .out_at_target_left    (out_at_target_left),
    .out_at_target_right   (out_at_target_right),
    .out_periods_accepted  (out_periods_accepted)
  );

  always #4 clk = ~clk;

  // Hard limit on the run time.
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  // Receiver stalls in random bursts while idling is enabled.
  always @(negedge clk) begin
    if (!idling || !rst_n) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 17) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Accepted requests feed the predictor before delivered results are checked.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      sb.note_request('{action_t'(in_action), in_reload_left, in_reload_right,
                        in_target_left_steps, in_target_right_steps});
    if (rst_n && out_valid && !out_stall)
      sb.check_result('{out_coils_left, out_coils_right, out_step_left, out_step_right,
                        out_at_target_left, out_at_target_right, out_periods_accepted});
  end

  function automatic motion_req_t req(action_t a, logic [TIMER_BITS-1:0] rl,
                                      logic [TIMER_BITS-1:0] rr,
                                      logic [POSITION_BITS-1:0] tl,
                                      logic [POSITION_BITS-1:0] tr);
    motion_req_t r;
    r.action       = a;
    r.reload_left  = rl;
    r.reload_right = rr;
    r.target_left  = tl;
    r.target_right = tr;
    return r;
  endfunction

  // Reloads cluster just above the limit so motors step often, with some noise.
  function automatic logic [TIMER_BITS-1:0] random_reload(logic [TIMER_BITS-1:0] limit);
    case ($urandom_range(0, 9))
      0:       return TIMER_BITS'($urandom);
      1:       return '0;
      2:       return (limit == '0) ? '1 : limit - 1'b1;
      default: return (limit > 16'hFFFB) ? limit : limit + TIMER_BITS'($urandom_range(0, 4));
    endcase
  endfunction

  // Targets are mostly short moves so halting steps are reached.
  function automatic logic [POSITION_BITS-1:0] random_target();
    case ($urandom_range(0, 9))
      0:       return POSITION_BITS'($urandom);
      1:       return '1;
      default: return POSITION_BITS'($urandom_range(0, 12));
    endcase
  endfunction

  function automatic motion_req_t random_request(logic [TIMER_BITS-1:0] limit);
    int          pick;
    motion_req_t r;
    pick = $urandom_range(0, 99);
    if (pick < 78)      r.action = ACT_TICK;
    else if (pick < 85) r.action = ACT_RUN;
    else if (pick < 95) r.action = ACT_MOVE;
    else                r.action = ACT_STOP;
    r.reload_left  = random_reload(limit);
    r.reload_right = random_reload(limit);
    r.target_left  = random_target();
    r.target_right = random_target();
    return r;
  endfunction

  // Present one request at a falling edge and hold it until it is accepted.
  task automatic send(motion_req_t r);
    if (idling && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_valid              <= 1'b1;
    in_action             <= r.action;
    in_reload_left        <= r.reload_left;
    in_reload_right       <= r.reload_right;
    in_target_left_steps  <= r.target_left;
    in_target_right_steps <= r.target_right;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Stop sending and wait until every expected result has been delivered.
  task automatic settle();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (sb.pending.size() != 0 && waited < 2000) begin
      @(negedge clk);
      waited++;
    end
    if (sb.pending.size() != 0)
      sb.report($sformatf("%0d results never delivered", sb.pending.size()));
    repeat (3) @(negedge clk);
  endtask

  task automatic set_min_reload(logic [TIMER_BITS-1:0] value);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.min_reload = value;
  endtask

  initial begin : stimulus
    int limits [6] = '{0, 3, 65535, 1, 100, 2};
    int counts [6] = '{300, 300, 80, 300, 300, 320};

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    idling = 1'b1;

    // Limit checks at the reset speed limit: exact limit, one below, mixed.
    send(req(ACT_TICK, '0, '0, '0, '0));
    send(req(ACT_RUN, 16'd100, 16'd100, '0, '0));
    send(req(ACT_RUN, 16'd99, 16'hFFFF, '0, '0));
    send(req(ACT_RUN, 16'hFFFF, 16'd100, '0, '0));
    send(req(ACT_MOVE, 16'd100, 16'd99, 20'hFFFFF, '0));
    send(req(ACT_MOVE, 16'hFFFF, 16'hFFFF, '0, 20'hFFFFF));
    send(req(ACT_STOP, '0, '0, '0, '0));
    send(req(ACT_TICK, '0, '0, '0, '0));

    // With no limit: stopped motors, short moves that halt, a lowered period.
    set_min_reload('0);
    send(req(ACT_RUN, '0, '0, '0, '0));
    send(req(ACT_TICK, '0, '0, '0, '0));
    send(req(ACT_MOVE, 16'd1, 16'd2, 20'd2, 20'd1));
    repeat (7) send(req(ACT_TICK, '0, '0, '0, '0));
    send(req(ACT_RUN, 16'd20, 16'd20, '0, '0));
    repeat (2) send(req(ACT_TICK, '0, '0, '0, '0));
    send(req(ACT_RUN, 16'd1, 16'd1, '0, '0));
    repeat (2) send(req(ACT_TICK, '0, '0, '0, '0));
    send(req(ACT_STOP, '0, '0, '0, '0));

    // Random traffic under several speed limits; the last phase runs without idling.
    for (int p = 0; p < 6; p++) begin
      set_min_reload(TIMER_BITS'(limits[p]));
      for (int i = 0; i < counts[p]; i++) begin
        if (p == 5)
          idling = 1'b0;
        else if (i % 50 == 0)
          idling = ($urandom_range(0, 3) != 0);
        send(random_request(TIMER_BITS'(limits[p])));
      end
    end

    settle();
    repeat (4) @(negedge clk);
    if (sb.errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
